[rtl/core/pn_pkg.sv]
// ----------------------------------------------------------------------------
// pn_pkg
// Shared types, constants and helpers for the path normalizer.
// ----------------------------------------------------------------------------
package pn_pkg;

    localparam int PATH_MAX    = 64;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = 6;
    localparam int LEN_W       = 7;

    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [LEN_W-1:0]  t_len;
    typedef logic [7:0]        t_char;

    localparam logic CMD_CWD = 1'b0;
    localparam logic CMD_REL = 1'b1;

    localparam t_char CH_NUL   = 8'h00;
    localparam t_char CH_SLASH = 8'h2F;
    localparam t_char CH_DOT   = 8'h2E;
    localparam t_char CH_DASH  = 8'h2D;
    localparam t_char CH_UNDER = 8'h5F;
    localparam t_char CH_0     = 8'h30;
    localparam t_char CH_9     = 8'h39;
    localparam t_char CH_UA    = 8'h41;
    localparam t_char CH_UZ    = 8'h5A;
    localparam t_char CH_LA    = 8'h61;
    localparam t_char CH_LZ    = 8'h7A;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_ABS  = 2'd1,
        ST_BAD_CHAR = 2'd2,
        ST_OVERFLOW = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_WALK_RD,
        FSM_WALK_CHK,
        FSM_FINISH,
        FSM_EMIT_RD,
        FSM_EMIT_OUT,
        FSM_ERR_OUT
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_WALK_READ,
        OP_WALK_STEP,
        OP_WALK_END,
        OP_EMIT_READ,
        OP_EMIT_NEXT,
        OP_CLEAR
    } t_dp_op;

    typedef struct packed {
        t_dp_op op;
        logic   out_err;
    } t_dp_cmd;

    typedef struct packed {
        logic walk;
        logic term;
        logic len_zero;
        logic rd_slash;
        logic emit_err;
        logic emit_last;
    } t_dp_stat;

    function automatic logic legal_char(input t_char c);
        legal_char = (c >= CH_0 && c <= CH_9) || (c >= CH_UA && c <= CH_UZ) ||
                     (c >= CH_LA && c <= CH_LZ) || c == CH_DASH || c == CH_DOT ||
                     c == CH_UNDER;
    endfunction

endpackage

[rtl/core/pn_datapath.sv]
// ----------------------------------------------------------------------------
// pn_datapath
// Path store, length and segment registers, and the result beat payload.
// ----------------------------------------------------------------------------
module pn_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pn_pkg::t_dp_cmd  i_cmd,
    input  logic             i_command,
    input  logic [7:0]       i_char_byte,
    output pn_pkg::t_dp_stat o_stat,
    output logic [7:0]       o_out_byte,
    output logic             o_last,
    output logic [1:0]       o_status
);
    import pn_pkg::*;

    t_char   mem [STORE_DEPTH];
    t_char   r_rd_data;

    t_len    r_len, n_len;
    t_len    r_seg, n_seg;
    logic [15:0] r_head, n_head;
    logic    r_rel, n_rel;
    t_status r_err, n_err;
    t_addr   r_k;

    logic    a_we;
    t_addr   a_waddr;
    t_char   a_wdata;
    logic    a_walk;

    t_len    len_m1;
    t_addr   rd_addr;

    // Update for one accepted byte; applied only on OP_ACCEPT.
    always_comb begin
        t_len    el;
        t_status ee;
        logic    fin;
        logic    sch;
        logic [7:0] base;
        logic [7:0] total;
        t_char   ha;
        t_char   hb;

        el      = r_len;
        ee      = r_err;
        fin     = 1'b0;
        sch     = 1'b0;
        n_len   = r_len;
        n_seg   = r_seg;
        n_head  = r_head;
        n_rel   = r_rel;
        a_we    = 1'b0;
        a_waddr = '0;
        a_wdata = i_char_byte;
        a_walk  = 1'b0;
        ha      = r_head[7:0];
        hb      = r_head[15:8];

        if (i_command == CMD_CWD) begin
            if (i_char_byte != CH_NUL) begin
                if (r_rel) begin
                    el     = '0;
                    ee     = ST_OK;
                    n_rel  = 1'b0;
                    n_seg  = '0;
                    n_head = '0;
                end
                if (ee != ST_OK) begin
                    // hold: run already failed
                end else if (el == '0 && i_char_byte != CH_SLASH) begin
                    ee = ST_NOT_ABS;
                end else if (el >= t_len'(PATH_MAX)) begin
                    ee = ST_OVERFLOW;
                end else begin
                    a_we    = 1'b1;
                    a_waddr = el[ADDR_W-1:0];
                    el      = el + t_len'(1);
                end
            end
        end else begin
            if (!r_rel) begin
                n_rel = 1'b1;
                if (ee == ST_OK && el == '0) begin
                    ee = ST_NOT_ABS;
                end
                if (ee == ST_OK && i_char_byte == CH_SLASH) begin
                    a_we    = 1'b1;
                    a_waddr = '0;
                    a_wdata = CH_SLASH;
                    el      = t_len'(1);
                end
            end
            if (i_char_byte == CH_NUL) begin
                fin = 1'b1;
            end else if (ee != ST_OK) begin
                // drop: run already failed
            end else if (i_char_byte == CH_SLASH) begin
                fin = 1'b1;
            end else if (!legal_char(i_char_byte)) begin
                ee = ST_BAD_CHAR;
            end else begin
                sch = 1'b1;
            end
        end

        base = {1'b0, el} + ((el > t_len'(1)) ? 8'd1 : 8'd0);

        if (fin) begin
            n_seg  = '0;
            n_head = '0;
            if (ee == ST_OK && r_seg != '0 && !(r_seg == t_len'(1) && ha == CH_DOT)) begin
                if (r_seg == t_len'(2) && ha == CH_DOT && hb == CH_DOT) begin
                    a_walk = 1'b1;
                end else begin
                    total = base + {1'b0, r_seg};
                    if (total > 8'(PATH_MAX)) begin
                        ee = ST_OVERFLOW;
                    end else begin
                        if (el > t_len'(1)) begin
                            a_we    = 1'b1;
                            a_waddr = el[ADDR_W-1:0];
                            a_wdata = CH_SLASH;
                        end
                        el = total[LEN_W-1:0];
                    end
                end
            end
        end

        // Head characters are stored ahead of time above the path end.
        total = base + {1'b0, r_seg};
        if (sch) begin
            if (r_seg < t_len'(2)) begin
                if (r_seg == '0) begin
                    n_head = {8'h00, i_char_byte};
                end else begin
                    n_head = {i_char_byte, r_head[7:0]};
                end
                if (total < 8'(PATH_MAX)) begin
                    a_we    = 1'b1;
                    a_waddr = total[ADDR_W-1:0];
                end
                n_seg = r_seg + t_len'(1);
            end else if (total >= 8'(PATH_MAX)) begin
                ee = ST_OVERFLOW;
            end else begin
                a_we    = 1'b1;
                a_waddr = total[ADDR_W-1:0];
                n_seg   = r_seg + t_len'(1);
            end
        end

        n_len = el;
        n_err = ee;
    end

    assign len_m1  = r_len - t_len'(1);
    assign rd_addr = (i_cmd.op == OP_WALK_READ) ? len_m1[ADDR_W-1:0] : r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len  <= '0;
            r_seg  <= '0;
            r_head <= '0;
            r_rel  <= 1'b0;
            r_err  <= ST_OK;
            r_k    <= '0;
        end else begin
            case (i_cmd.op)
                OP_ACCEPT: begin
                    r_len  <= n_len;
                    r_seg  <= n_seg;
                    r_head <= n_head;
                    r_rel  <= n_rel;
                    r_err  <= n_err;
                end
                OP_WALK_STEP: begin
                    r_len <= len_m1;
                end
                OP_WALK_END: begin
                    if (r_len > t_len'(1)) begin
                        r_len <= len_m1;
                    end
                end
                OP_EMIT_NEXT: begin
                    r_k <= r_k + t_addr'(1);
                end
                OP_CLEAR: begin
                    r_len  <= '0;
                    r_seg  <= '0;
                    r_head <= '0;
                    r_rel  <= 1'b0;
                    r_err  <= ST_OK;
                    r_k    <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_ACCEPT && a_we) begin
            mem[a_waddr] <= a_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WALK_READ || i_cmd.op == OP_EMIT_READ) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    assign o_stat.walk      = a_walk;
    assign o_stat.term      = (i_command == CMD_REL) && (i_char_byte == CH_NUL);
    assign o_stat.len_zero  = (r_len == '0);
    assign o_stat.rd_slash  = (r_rd_data == CH_SLASH);
    assign o_stat.emit_err  = (r_err != ST_OK) || (r_len == '0);
    assign o_stat.emit_last = (({1'b0, r_k} + t_len'(1)) == r_len);

    assign o_out_byte = i_cmd.out_err ? CH_NUL : r_rd_data;
    assign o_last     = i_cmd.out_err ? 1'b1 : o_stat.emit_last;
    assign o_status   = !i_cmd.out_err ? ST_OK :
                        (r_err != ST_OK) ? r_err : ST_NOT_ABS;

endmodule

[rtl/core/pn_ctrl.sv]
// ----------------------------------------------------------------------------
// pn_ctrl
// Sequencer: accept bytes, walk back on parent segments, stream the result.
// ----------------------------------------------------------------------------
module pn_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_out_ready,
    input  pn_pkg::t_dp_stat i_stat,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output pn_pkg::t_dp_cmd  o_cmd
);
    import pn_pkg::*;

    t_state r_state, n_state;
    logic   r_term, n_term;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= FSM_IDLE;
            r_term  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_term  <= n_term;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_term  = r_term;
        case (r_state)
            FSM_IDLE: begin
                if (i_in_valid) begin
                    n_term = i_stat.term;
                    if (i_stat.walk) begin
                        n_state = FSM_WALK_RD;
                    end else if (i_stat.term) begin
                        n_state = FSM_FINISH;
                    end
                end
            end
            FSM_WALK_RD: begin
                if (i_stat.len_zero) begin
                    n_state = r_term ? FSM_FINISH : FSM_IDLE;
                end else begin
                    n_state = FSM_WALK_CHK;
                end
            end
            FSM_WALK_CHK: begin
                if (i_stat.rd_slash) begin
                    n_state = r_term ? FSM_FINISH : FSM_IDLE;
                end else begin
                    n_state = FSM_WALK_RD;
                end
            end
            FSM_FINISH: begin
                n_state = i_stat.emit_err ? FSM_ERR_OUT : FSM_EMIT_RD;
            end
            FSM_EMIT_RD: begin
                n_state = FSM_EMIT_OUT;
            end
            FSM_EMIT_OUT: begin
                if (i_out_ready) begin
                    n_state = i_stat.emit_last ? FSM_IDLE : FSM_EMIT_RD;
                end
            end
            FSM_ERR_OUT: begin
                if (i_out_ready) begin
                    n_state = FSM_IDLE;
                end
            end
            default: begin
                n_state = FSM_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_in_ready    = 1'b0;
        o_out_valid   = 1'b0;
        o_cmd.op      = OP_NONE;
        o_cmd.out_err = 1'b0;
        case (r_state)
            FSM_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.op = OP_ACCEPT;
                end
            end
            FSM_WALK_RD: begin
                o_cmd.op = i_stat.len_zero ? OP_WALK_END : OP_WALK_READ;
            end
            FSM_WALK_CHK: begin
                o_cmd.op = i_stat.rd_slash ? OP_WALK_END : OP_WALK_STEP;
            end
            FSM_EMIT_RD: begin
                o_cmd.op = OP_EMIT_READ;
            end
            FSM_EMIT_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    o_cmd.op = i_stat.emit_last ? OP_CLEAR : OP_EMIT_NEXT;
                end
            end
            FSM_ERR_OUT: begin
                o_out_valid   = 1'b1;
                o_cmd.out_err = 1'b1;
                if (i_out_ready) begin
                    o_cmd.op = OP_CLEAR;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/core/path_normalizer.sv]
// Accept: a plain path byte is taken directly; a ".." segment instead walks the stored path back
//   a character at a time (read, then check) until it stops on a '/' or the path empties.
// Throughput: one input beat per cycle except during a walk-back or emission.
// Terminator: a settle state, then each path beat is read from the store read port before it
//   is offered, or the error beat is offered; input is held off until the last beat is taken.
// Reset (synchronous, i_rst_n low): control and lengths clear; the store is not cleared.
// ----------------------------------------------------------------------------
// path_normalizer
// Lexical path canonicalization: a working directory and a relative path come
// in one byte per beat; the normalized path, or one error beat, goes out.
// ----------------------------------------------------------------------------
module path_normalizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_byte
    input  logic       s_axis_tuser,   // [0] command (0 cwd byte, 1 relative byte)
    // result stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // last beat of the run
    output logic [1:0] m_axis_tuser    // [1:0] status
);
    import pn_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer: owns the handshakes and steps the datapath through
    // accept, walk-back and emission.
    pn_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (dp_stat),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_cmd       (dp_cmd)
    );

    // Datapath: path store with a registered read port, lengths, segment
    // head and the sticky error code; drives the result beat payload.
    pn_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .i_command   (s_axis_tuser),
        .i_char_byte (s_axis_tdata),
        .o_stat      (dp_stat),
        .o_out_byte  (m_axis_tdata),
        .o_last      (m_axis_tlast),
        .o_status    (m_axis_tuser)
    );

    // One item at a time: never take input while a result beat is offered.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("input ready while result pending");

    // An error beat is a single, final, zero beat.
    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tlast && m_axis_tdata == CH_NUL))
        else $error("error beat not final or not zero");

    // After the last beat of a run the block returns to taking input.
    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> s_axis_tready)
        else $error("block not idle after last beat");

endmodule
